FILE: src/ectc_pkg.sv
// ----------------------------------------------------------------------------
// ectc_pkg: shared constants for the epoch / civil time converter
// Calendar constants, action codes and the March-based month start table.
// ----------------------------------------------------------------------------
package ectc_pkg;

  localparam int unsigned SECONDS_BITS_DEF = 41;
  // widest exact total of a fields-to-seconds conversion
  localparam int unsigned EXACT_W          = 52;
  localparam int unsigned SEC_PER_DAY      = 86400;
  localparam int unsigned DAYS_PER_ERA     = 146097;
  // days from 0000-03-01 to 1970-01-01
  localparam int unsigned EPOCH_SHIFT      = 719468;
  // quotient bits resolved per divider stage
  localparam int unsigned DIV_STEP         = 4;

  localparam logic ACT_TO_CIVIL   = 1'b0;
  localparam logic ACT_TO_SECONDS = 1'b1;

  // first day of month mp in a year starting on March 1 (mp 0 = March)
  function automatic logic [8:0] mar_start(input logic [3:0] mp);
    logic [8:0] r;
    unique case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: src/ectc_cdiv.sv
// ----------------------------------------------------------------------------
// ectc_cdiv: pipelined unsigned division by a constant
// Restoring division, STEP quotient bits per register stage, side payload.
// ----------------------------------------------------------------------------
module ectc_cdiv import ectc_pkg::*; #(
  parameter int unsigned NW   = 40,
  parameter int unsigned DIV  = SEC_PER_DAY,
  parameter int unsigned PW   = 1,
  parameter int unsigned STEP = DIV_STEP,
  localparam int unsigned RW  = $clog2(DIV)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [PW-1:0] pay_i,
  output logic          vld_o,
  output logic [NW-1:0] quo_o,
  output logic [RW-1:0] rem_o,
  output logic [PW-1:0] pay_o
);

  localparam int unsigned NS = (NW + STEP - 1) / STEP;
  localparam int unsigned NP = NS * STEP;

  logic [NS-1:0] vld_q;
  logic [RW-1:0] r_q   [NS];
  logic [NP-1:0] nq_q  [NS];
  logic [PW-1:0] pay_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [RW-1:0] r_in, r_d;
    logic [NP-1:0] nq_in, nq_d;
    logic          v_in;
    logic [PW-1:0] p_in;

    if (s == 0) begin : g_first
      assign r_in  = '0;
      assign nq_in = NP'(num_i);
      assign v_in  = vld_i;
      assign p_in  = pay_i;
    end else begin : g_next
      assign r_in  = r_q[s-1];
      assign nq_in = nq_q[s-1];
      assign v_in  = vld_q[s-1];
      assign p_in  = pay_q[s-1];
    end

    // dividend bits shift out at the top, quotient bits shift in at the bottom
    always_comb begin : step_b
      logic [RW:0] t;
      r_d  = r_in;
      nq_d = nq_in;
      for (int j = 0; j < STEP; j++) begin
        t    = {r_d, nq_d[NP-1]};
        nq_d = {nq_d[NP-2:0], 1'b0};
        if (t >= (RW+1)'(DIV)) begin
          t       = t - (RW+1)'(DIV);
          nq_d[0] = 1'b1;
        end
        r_d = t[RW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s]   <= r_d;
        nq_q[s]  <= nq_d;
        pay_q[s] <= p_in;
      end
    end
  end

  assign vld_o = vld_q[NS-1];
  assign quo_o = nq_q[NS-1][NW-1:0];
  assign rem_o = r_q[NS-1];
  assign pay_o = pay_q[NS-1];

endmodule

FILE: src/epoch_civil_time_converter_unit.sv
// ----------------------------------------------------------------------------
// epoch_civil_time_converter_unit: epoch seconds <-> Gregorian UTC fields
// Fully pipelined converter, one transaction per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Input channel (s_axis): tuser selects the action. Action 0 splits
// seconds_in into civil fields; action 1 builds the epoch seconds from
// unnormalized fields and returns them with the normalized fields.
// Output channel (m_axis): one result transaction per input transaction,
// in order; tuser carries the out-of-range flag.
// Throughput: one transaction per cycle unless the output stalls. Pipeline:
// five front stages (field to day count and total), the
// seconds-per-day divider (one stage per 4 quotient bits), one stage, the
// days-per-era divider, then six stages of calendar math incl. the output
// register. SECONDS_BITS above EXACT_W adds divider stages.
// Reset clears all valid bits; the pipeline empties and tready is high.
// Stall: when a result waits and m_axis_tready is low, the whole pipeline
// holds and s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module epoch_civil_time_converter_unit import ectc_pkg::*; #(
  parameter int unsigned SECONDS_BITS = SECONDS_BITS_DEF,
  localparam int unsigned IN_W  = ((SECONDS_BITS + 148 + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((SECONDS_BITS + 55 + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // seconds_in, sec_in, min_in, hour_in, mday_in, mon_in, year_in
  input  logic [IN_W-1:0]  s_axis_tdata,
  // action
  input  logic [0:0]       s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // seconds_out, sec_out, min_out, hour_out, mday_out, mon_out, year_out,
  // wday_out, yday_out
  output logic [OUT_W-1:0] m_axis_tdata,
  // out_of_range
  output logic [0:0]       m_axis_tuser
);

  localparam int unsigned SB = SECONDS_BITS;
  localparam int unsigned TW = (SB > EXACT_W) ? SB : EXACT_W;
  localparam int unsigned DW = TW - 16;
  localparam int unsigned ZW = DW + 1;
  localparam int unsigned EW = ZW - 17;
  localparam int unsigned YW = EW + 10;

  // reciprocal multipliers for exact small divisions
  localparam longint unsigned M25   = ((64'd1 << 17) + 64'd24) / 64'd25;
  localparam longint unsigned M1460 = ((64'd1 << 29) + 64'd1459) / 64'd1460;
  localparam longint unsigned M365  = ((64'd1 << 27) + 64'd364) / 64'd365;
  localparam longint unsigned M3600 = ((64'd1 << 29) + 64'd3599) / 64'd3600;
  localparam longint unsigned M7    = ((64'd1 << 21) + 64'd6) / 64'd7;
  localparam longint unsigned M60   = ((64'd1 << 18) + 64'd59) / 64'd60;
  localparam longint unsigned M153  = ((64'd1 << 19) + 64'd152) / 64'd153;

  logic en;
  logic vld_q;

  // whole pipeline advances unless a result waits
  assign en            = !vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------- front p1: month carry, shifted year, month start
  logic               vld_p1_q, act_p1_q;
  logic [SB-1:0]      secs_p1_q;
  logic signed [31:0] sec_p1_q, min_p1_q, hr_p1_q, md_p1_q;
  logic [16:0]        yp_p1_q;
  logic [8:0]         cm_p1_q;
  logic [16:0]        yp_d;
  logic [8:0]         cm_d;

  always_comb begin : front_p1
    logic [3:0]         mon_in, mon_a, mp_a;
    logic signed [15:0] year_in;
    logic               mon_hi;
    logic signed [17:0] ya;
    mon_in  = s_axis_tdata[SB+128 +: 4];
    year_in = s_axis_tdata[SB+132 +: 16];
    mon_hi  = (mon_in >= 4'd12);
    mon_a   = mon_hi ? mon_in - 4'd12 : mon_in;
    // January and February count with the previous March-based year
    ya      = 18'(year_in) + 18'sd1900 + {17'd0, mon_hi} - {17'd0, (mon_a < 4'd2)};
    yp_d    = 17'(ya + 18'sd40000);
    mp_a    = (mon_a < 4'd2) ? mon_a + 4'd10 : mon_a - 4'd2;
    cm_d    = mar_start(mp_a);
  end

  // ---------------- p2: day count of the month start, time products
  logic               vld_p2_q, act_p2_q;
  logic [SB-1:0]      secs_p2_q;
  logic [25:0]        dc_p2_q;
  logic signed [43:0] h_p2_q;
  logic signed [37:0] m_p2_q;
  logic signed [31:0] sec_p2_q, md_p2_q;
  logic [25:0]        dc_d;
  logic signed [43:0] h_d;
  logic signed [37:0] m_d;

  always_comb begin : front_p2
    logic [25:0] y365;
    logic [14:0] q100, q400;
    y365 = 26'(yp_p1_q) * 26'd365;
    q100 = 15'((28'(yp_p1_q[16:2]) * 28'(M25)) >> 17);
    q400 = 15'((28'(yp_p1_q[16:4]) * 28'(M25)) >> 17);
    dc_d = y365 + 26'(yp_p1_q[16:2]) - 26'(q100) + 26'(q400) + 26'(cm_p1_q);
    h_d  = 44'(hr_p1_q) * 44'sd3600;
    m_d  = 38'(min_p1_q) * 38'sd60;
  end

  // ---------------- p3: epoch day number, time of day sum
  logic               vld_p3_q, act_p3_q;
  logic [SB-1:0]      secs_p3_q;
  logic signed [33:0] days_p3_q;
  logic signed [44:0] hm_p3_q;
  logic signed [33:0] days_d;
  logic signed [44:0] hm_d;

  always_comb begin : front_p3
    days_d = $signed({8'd0, dc_p2_q}) - 34'sd15329168 + 34'(md_p2_q) - 34'sd1;
    hm_d   = 45'(h_p2_q) + 45'(m_p2_q) + 45'(sec_p2_q);
  end

  // ---------------- p4: days to seconds
  logic               vld_p4_q, act_p4_q;
  logic [SB-1:0]      secs_p4_q;
  logic signed [51:0] dmul_p4_q;
  logic signed [44:0] hm_p4_q;
  logic signed [51:0] dmul_d;

  assign dmul_d = 52'(days_p3_q) * 52'sd86400;

  // ---------------- p5: total seconds and range check
  logic               vld_p5_q, over_p5_q;
  logic [TW-1:0]      tot_p5_q;
  logic [TW-1:0]      tot_d;
  logic               over_d;

  always_comb begin : front_p5
    logic signed [51:0]   sum52;
    logic signed [TW-1:0] tot_x, hi;
    sum52  = dmul_p4_q + 52'(hm_p4_q);
    tot_x  = TW'(sum52);
    hi     = tot_x >>> (SB - 1);
    over_d = (act_p4_q == ACT_TO_SECONDS) && !(hi == '0 || hi == '1);
    tot_d  = (act_p4_q == ACT_TO_SECONDS) ? tot_x : TW'(signed'(secs_p4_q));
  end

  // front valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_p1_q <= 1'b0;
      vld_p2_q <= 1'b0;
      vld_p3_q <= 1'b0;
      vld_p4_q <= 1'b0;
      vld_p5_q <= 1'b0;
    end else if (en) begin
      vld_p1_q <= s_axis_tvalid;
      vld_p2_q <= vld_p1_q;
      vld_p3_q <= vld_p2_q;
      vld_p4_q <= vld_p3_q;
      vld_p5_q <= vld_p4_q;
    end
  end

  // front payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      act_p1_q  <= s_axis_tuser[0];
      secs_p1_q <= s_axis_tdata[SB-1:0];
      sec_p1_q  <= s_axis_tdata[SB +: 32];
      min_p1_q  <= s_axis_tdata[SB+32 +: 32];
      hr_p1_q   <= s_axis_tdata[SB+64 +: 32];
      md_p1_q   <= s_axis_tdata[SB+96 +: 32];
      yp_p1_q   <= yp_d;
      cm_p1_q   <= cm_d;
      act_p2_q  <= act_p1_q;
      secs_p2_q <= secs_p1_q;
      dc_p2_q   <= dc_d;
      h_p2_q    <= h_d;
      m_p2_q    <= m_d;
      sec_p2_q  <= sec_p1_q;
      md_p2_q   <= md_p1_q;
      act_p3_q  <= act_p2_q;
      secs_p3_q <= secs_p2_q;
      days_p3_q <= days_d;
      hm_p3_q   <= hm_d;
      act_p4_q  <= act_p3_q;
      secs_p4_q <= secs_p3_q;
      dmul_p4_q <= dmul_d;
      hm_p4_q   <= hm_p3_q;
      over_p5_q <= over_d;
      tot_p5_q  <= tot_d;
    end
  end

  // ---------------- floor division by seconds per day (ones-complement fold)
  logic          dv1_vld;
  logic [TW-2:0] dv1_quo;
  logic [16:0]   dv1_rem;
  logic [SB+1:0] dv1_pay;

  ectc_cdiv #(
    .NW  (TW - 1),
    .DIV (SEC_PER_DAY),
    .PW  (SB + 2)
  ) u_div_day (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_p5_q),
    .num_i  (tot_p5_q[TW-2:0] ^ {(TW-1){tot_p5_q[TW-1]}}),
    .pay_i  ({over_p5_q, tot_p5_q[SB-1:0], tot_p5_q[TW-1]}),
    .vld_o  (dv1_vld),
    .quo_o  (dv1_quo),
    .rem_o  (dv1_rem),
    .pay_o  (dv1_pay)
  );

  // ---------------- f1: day number shifted to 0000-03-01
  logic          vld_f1_q, over_f1_q;
  logic [ZW-1:0] z_f1_q;
  logic [16:0]   rem_f1_q;
  logic [SB-1:0] secs_f1_q;
  logic [ZW-1:0] z_d;
  logic [16:0]   rem_d;

  always_comb begin : mid_f1
    logic          neg1;
    logic [DW-1:0] days1;
    neg1  = dv1_pay[0];
    days1 = {neg1, dv1_quo[DW-2:0] ^ {(DW-1){neg1}}};
    rem_d = neg1 ? 17'(SEC_PER_DAY - 1) - dv1_rem : dv1_rem;
    z_d   = ZW'(signed'(days1)) + ZW'(EPOCH_SHIFT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_f1_q <= 1'b0;
    end else if (en) begin
      vld_f1_q <= dv1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      z_f1_q    <= z_d;
      rem_f1_q  <= rem_d;
      secs_f1_q <= dv1_pay[SB:1];
      over_f1_q <= dv1_pay[SB+1];
    end
  end

  // ---------------- floor division by days per 400-year era
  logic           dv2_vld;
  logic [ZW-2:0]  dv2_quo;
  logic [17:0]    dv2_rem;
  logic [SB+18:0] dv2_pay;

  ectc_cdiv #(
    .NW  (ZW - 1),
    .DIV (DAYS_PER_ERA),
    .PW  (SB + 19)
  ) u_div_era (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_f1_q),
    .num_i  (z_f1_q[ZW-2:0] ^ {(ZW-1){z_f1_q[ZW-1]}}),
    .pay_i  ({over_f1_q, secs_f1_q, rem_f1_q, z_f1_q[ZW-1]}),
    .vld_o  (dv2_vld),
    .quo_o  (dv2_quo),
    .rem_o  (dv2_rem),
    .pay_o  (dv2_pay)
  );

  // ---------------- r1: era and day of era
  logic          vld_r1_q, over_r1_q;
  logic [EW-1:0] era_r1_q;
  logic [17:0]   doe_r1_q;
  logic [16:0]   rem_r1_q;
  logic [SB-1:0] secs_r1_q;
  logic [EW-1:0] era_d;
  logic [17:0]   doe_d;

  always_comb begin : back_r1
    logic neg2;
    neg2  = dv2_pay[0];
    era_d = {neg2, dv2_quo[EW-2:0] ^ {(EW-1){neg2}}};
    doe_d = neg2 ? 18'(DAYS_PER_ERA - 1) - dv2_rem : dv2_rem;
  end

  // ---------------- r2: leap corrections, hour, weekday quotient
  logic        vld_r2_q, over_r2_q;
  logic [17:0] t_r2_q, doe_r2_q;
  logic [4:0]  hour_r2_q;
  logic [14:0] q7_r2_q;
  logic [16:0] rem_r2_q;
  logic [EW-1:0] era_r2_q;
  logic [SB-1:0] secs_r2_q;
  logic [17:0] t_d;
  logic [4:0]  hour_d;
  logic [14:0] q7_d;

  always_comb begin : back_r2
    logic [6:0] a;
    logic [2:0] b;
    logic       c;
    a      = 7'((37'(doe_r1_q) * 37'(M1460)) >> 29);
    b      = 3'(doe_r1_q >= 18'd36524) + 3'(doe_r1_q >= 18'd73048) +
             3'(doe_r1_q >= 18'd109572) + 3'(doe_r1_q >= 18'd146096);
    c      = (doe_r1_q == 18'(DAYS_PER_ERA - 1));
    t_d    = doe_r1_q - 18'(a) + 18'(b) - 18'(c);
    hour_d = 5'((35'(rem_r1_q) * 35'(M3600)) >> 29);
    q7_d   = 15'((37'(doe_r1_q + 18'd3) * 37'(M7)) >> 21);
  end

  // ---------------- r3: year of era, seconds of hour, weekday
  logic        vld_r3_q, over_r3_q;
  logic [8:0]  yoe_r3_q;
  logic [11:0] rs_r3_q;
  logic [2:0]  wday_r3_q;
  logic [17:0] doe_r3_q;
  logic [4:0]  hour_r3_q;
  logic [EW-1:0] era_r3_q;
  logic [SB-1:0] secs_r3_q;
  logic [8:0]  yoe_d;
  logic [11:0] rs_d;
  logic [2:0]  wday_d;

  always_comb begin : back_r3
    yoe_d  = 9'((37'(t_r2_q) * 37'(M365)) >> 27);
    rs_d   = 12'(rem_r2_q - 17'(hour_r2_q) * 17'd3600);
    // 146097 days is a whole number of weeks
    wday_d = 3'(doe_r2_q + 18'd3 - 18'(q7_r2_q) * 18'd7);
  end

  // ---------------- r4: day of March-based year, leap flag, minute
  logic        vld_r4_q, over_r4_q, leap_r4_q;
  logic [8:0]  doy_r4_q, yoe_r4_q;
  logic [5:0]  min_r4_q;
  logic [11:0] rs_r4_q;
  logic [2:0]  wday_r4_q;
  logic [4:0]  hour_r4_q;
  logic [EW-1:0] era_r4_q;
  logic [SB-1:0] secs_r4_q;
  logic [8:0]  doy_d;
  logic        leap_d;
  logic [5:0]  min_d;

  always_comb begin : back_r4
    logic [1:0] yc;
    logic       cent;
    yc     = 2'(yoe_r3_q >= 9'd100) + 2'(yoe_r3_q >= 9'd200) + 2'(yoe_r3_q >= 9'd300);
    doy_d  = 9'(doe_r3_q - (18'(yoe_r3_q) * 18'd365 + 18'(yoe_r3_q[8:2]) - 18'(yc)));
    cent   = (yoe_r3_q == 9'd100) || (yoe_r3_q == 9'd200) || (yoe_r3_q == 9'd300);
    leap_d = (yoe_r3_q[1:0] == 2'd0) && !cent;
    min_d  = 6'((25'(rs_r3_q) * 25'(M60)) >> 18);
  end

  // ---------------- r5: month index, second
  logic        vld_r5_q, over_r5_q, leap_r5_q;
  logic [3:0]  mp_r5_q;
  logic [8:0]  doy_r5_q, yoe_r5_q;
  logic [5:0]  min_r5_q, sec_r5_q;
  logic [2:0]  wday_r5_q;
  logic [4:0]  hour_r5_q;
  logic [EW-1:0] era_r5_q;
  logic [SB-1:0] secs_r5_q;
  logic [3:0]  mp_d;
  logic [5:0]  sec_d;

  always_comb begin : back_r5
    logic [10:0] x;
    x     = 11'(doy_r4_q) * 11'd5 + 11'd2;
    mp_d  = 4'((23'(x) * 23'(M153)) >> 19);
    sec_d = 6'(rs_r4_q - 12'(min_r4_q) * 12'd60);
  end

  // ---------------- output register: all fields; month, day, year, day of year made here
  logic [SB-1:0] secs_q;
  logic [5:0]    sec_q, min_q;
  logic [4:0]    hour_q, mday_q;
  logic [3:0]    mon_q;
  logic [16:0]   year_q;
  logic [2:0]    wday_q;
  logic [8:0]    yday_q;
  logic          oor_q;
  logic [4:0]    mday_d;
  logic [3:0]    mon_d;
  logic [16:0]   year_d;
  logic [8:0]    yday_d;
  logic          oor_d;

  always_comb begin : back_out
    logic                 jf;
    logic signed [YW-1:0] era_x, ys, hiy;
    jf     = (mp_r5_q >= 4'd10);
    mday_d = 5'(doy_r5_q - mar_start(mp_r5_q) + 9'd1);
    mon_d  = jf ? mp_r5_q - 4'd10 : mp_r5_q + 4'd2;
    era_x  = YW'(signed'(era_r5_q));
    ys     = (era_x <<< 8) + (era_x <<< 7) + (era_x <<< 4) + YW'(yoe_r5_q) + YW'(jf) -
             YW'(1900);
    hiy    = ys >>> 16;
    year_d = ys[16:0];
    oor_d  = over_r5_q || !(hiy == '0 || hiy == '1);
    yday_d = jf ? doy_r5_q - 9'd306 : doy_r5_q + 9'd59 + 9'(leap_r5_q);
  end

  // back valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_r1_q <= 1'b0;
      vld_r2_q <= 1'b0;
      vld_r3_q <= 1'b0;
      vld_r4_q <= 1'b0;
      vld_r5_q <= 1'b0;
      vld_q    <= 1'b0;
    end else if (en) begin
      vld_r1_q <= dv2_vld;
      vld_r2_q <= vld_r1_q;
      vld_r3_q <= vld_r2_q;
      vld_r4_q <= vld_r3_q;
      vld_r5_q <= vld_r4_q;
      vld_q    <= vld_r5_q;
    end
  end

  // back payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      era_r1_q  <= era_d;
      doe_r1_q  <= doe_d;
      rem_r1_q  <= dv2_pay[17:1];
      secs_r1_q <= dv2_pay[SB+17:18];
      over_r1_q <= dv2_pay[SB+18];

      t_r2_q    <= t_d;
      doe_r2_q  <= doe_r1_q;
      hour_r2_q <= hour_d;
      q7_r2_q   <= q7_d;
      rem_r2_q  <= rem_r1_q;
      era_r2_q  <= era_r1_q;
      secs_r2_q <= secs_r1_q;
      over_r2_q <= over_r1_q;

      yoe_r3_q  <= yoe_d;
      rs_r3_q   <= rs_d;
      wday_r3_q <= wday_d;
      doe_r3_q  <= doe_r2_q;
      hour_r3_q <= hour_r2_q;
      era_r3_q  <= era_r2_q;
      secs_r3_q <= secs_r2_q;
      over_r3_q <= over_r2_q;

      doy_r4_q  <= doy_d;
      leap_r4_q <= leap_d;
      yoe_r4_q  <= yoe_r3_q;
      min_r4_q  <= min_d;
      rs_r4_q   <= rs_r3_q;
      wday_r4_q <= wday_r3_q;
      hour_r4_q <= hour_r3_q;
      era_r4_q  <= era_r3_q;
      secs_r4_q <= secs_r3_q;
      over_r4_q <= over_r3_q;

      mp_r5_q   <= mp_d;
      doy_r5_q  <= doy_r4_q;
      leap_r5_q <= leap_r4_q;
      yoe_r5_q  <= yoe_r4_q;
      min_r5_q  <= min_r4_q;
      sec_r5_q  <= sec_d;
      wday_r5_q <= wday_r4_q;
      hour_r5_q <= hour_r4_q;
      era_r5_q  <= era_r4_q;
      secs_r5_q <= secs_r4_q;
      over_r5_q <= over_r4_q;

      secs_q    <= secs_r5_q;
      sec_q     <= sec_r5_q;
      min_q     <= min_r5_q;
      hour_q    <= hour_r5_q;
      mday_q    <= mday_d;
      mon_q     <= mon_d;
      year_q    <= year_d;
      wday_q    <= wday_r5_q;
      yday_q    <= yday_d;
      oor_q     <= oor_d;
    end
  end

  // result packing
  always_comb begin : pack_out
    m_axis_tdata                = '0;
    m_axis_tdata[SB-1:0]        = secs_q;
    m_axis_tdata[SB +: 6]       = sec_q;
    m_axis_tdata[SB+6 +: 6]     = min_q;
    m_axis_tdata[SB+12 +: 5]    = hour_q;
    m_axis_tdata[SB+17 +: 5]    = mday_q;
    m_axis_tdata[SB+22 +: 4]    = mon_q;
    m_axis_tdata[SB+26 +: 17]   = year_q;
    m_axis_tdata[SB+43 +: 3]    = wday_q;
    m_axis_tdata[SB+46 +: 9]    = yday_q;
  end

  assign m_axis_tuser  = oor_q;
  assign m_axis_tvalid = vld_q;

endmodule
